### design/fidm_pkg.sv
// Package for the frame interval drop monitor: field widths, beat layout and
// the default refresh period. No dependencies.
package fidm_pkg;

  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned OUT_DATA_W = 5 * FIELD_W;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [FIELD_W-1:0] PERIOD_DEFAULT = 32'd16667;
  localparam logic [FIELD_W-1:0] ALL_ONES       = '1;

  // out_tdata field offsets
  localparam int unsigned OFS_FRAME_INDEX   = 0;
  localparam int unsigned OFS_INTERVAL      = 32;
  localparam int unsigned OFS_MISSED        = 64;
  localparam int unsigned OFS_MAX_INTERVAL  = 96;
  localparam int unsigned OFS_DROPPED_TOTAL = 128;

  // out_tuser bit positions
  localparam int unsigned USR_HAS_INTERVAL = 0;
  localparam int unsigned USR_DROPPED      = 1;

endpackage

### design/frame_interval_drop_monitor.sv
// Frame interval drop monitor: interval, missed-vblank count and running stats
// per swap timestamp, with a bit-serial restoring divider. Depends on fidm_pkg.
//
// Usage:
//   in_*   : one beat per frame swap; in_tdata is swap_time in microsecond ticks.
//   out_*  : one beat per input beat. out_tdata carries frame_index, interval,
//            missed, max_interval and dropped_total (lowest bits first);
//            out_tuser carries has_interval (bit 0) and dropped (bit 1).
//   cfg_*  : write of period_ticks, always ready; a period of zero acts as
//            16667 ticks (60 Hz). Write only while the block is idle.
//   Flow   : an item goes from acceptance to its result beat through the
//            timestamp difference, the divider (one quotient bit per cycle)
//            and the statistics update. A new item is taken once the previous
//            result has moved into the output register, so only one item is
//            in the block at a time.
//   Reset  : rst_n low clears all statistics, the first-swap flag and the
//            output valid flag, and loads the default period.
//   Stall  : the result waits in the output register; the next item is still
//            accepted and processed, and holds in its last step until the
//            output register frees.
module frame_interval_drop_monitor
  import fidm_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [FIELD_W-1:0]    in_tdata,   // [31:0] swap_time
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // frame_index, interval, missed,
                                            // max_interval, dropped_total
  output logic [OUT_USER_W-1:0] out_tuser,  // has_interval, dropped
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [FIELD_W-1:0]    cfg_data    // [31:0] period_ticks
);

  localparam int unsigned DW = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;

  typedef enum logic [1:0] {S_IDLE, S_DIFF, S_DIV, S_FIN} state_t;

  state_t                  state_r, state_nxt;
  logic [TIME_BITS-1:0]    now_r, now_nxt;
  logic [TIME_BITS-1:0]    last_time_r, last_time_nxt;
  logic                    seen_first_r, seen_first_nxt;
  logic [FIELD_W-1:0]      swap_count_r, swap_count_nxt;
  logic [FIELD_W-1:0]      longest_r, longest_nxt;
  logic [FIELD_W-1:0]      drop_events_r, drop_events_nxt;
  logic [FIELD_W-1:0]      period_r, period_nxt;
  logic [FIELD_W-1:0]      divisor_r, divisor_nxt;
  logic [FIELD_W-1:0]      ivl_r, ivl_nxt;
  logic [FIELD_W-1:0]      dq_r, dq_nxt;
  logic [FIELD_W:0]        rem_r, rem_nxt;
  logic [4:0]              bit_cnt_r, bit_cnt_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]   out_tdata_r, out_tdata_nxt;
  logic [OUT_USER_W-1:0]   out_tuser_r, out_tuser_nxt;

  logic [TIME_BITS-1:0]    diff;
  logic [DW-1:0]           diff_ext;
  logic [FIELD_W:0]        rem_sh;
  logic                    rem_ge;
  logic                    drop;
  logic [FIELD_W-1:0]      missed;
  logic [FIELD_W-1:0]      max_ivl;
  logic [FIELD_W-1:0]      drops;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign diff     = now_r - last_time_r;
  assign diff_ext = DW'(diff);
  assign rem_sh   = {rem_r[FIELD_W-1:0], dq_r[FIELD_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, divisor_r};

  assign drop    = seen_first_r && (|dq_r[FIELD_W-1:1]);
  assign missed  = drop ? dq_r - FIELD_W'(1) : '0;
  assign max_ivl = (seen_first_r && (ivl_r > longest_r)) ? ivl_r : longest_r;
  assign drops   = (drop && (drop_events_r != ALL_ONES)) ? drop_events_r + FIELD_W'(1)
                                                         : drop_events_r;

  always_comb begin
    state_nxt       = state_r;
    now_nxt         = now_r;
    last_time_nxt   = last_time_r;
    seen_first_nxt  = seen_first_r;
    swap_count_nxt  = swap_count_r;
    longest_nxt     = longest_r;
    drop_events_nxt = drop_events_r;
    period_nxt      = period_r;
    divisor_nxt     = divisor_r;
    ivl_nxt         = ivl_r;
    dq_nxt          = dq_r;
    rem_nxt         = rem_r;
    bit_cnt_nxt     = bit_cnt_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_tdata_nxt   = out_tdata_r;
    out_tuser_nxt   = out_tuser_r;

    if (cfg_valid) begin
      period_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          now_nxt     = TIME_BITS'(in_tdata);
          divisor_nxt = (period_r == '0) ? PERIOD_DEFAULT : period_r;
          state_nxt   = S_DIFF;
        end
      end
      S_DIFF: begin
        // saturate a difference wider than the interval field
        if (!seen_first_r) begin
          ivl_nxt = '0;
        end else if ((diff_ext >> FIELD_W) != '0) begin
          ivl_nxt = ALL_ONES;
        end else begin
          ivl_nxt = diff_ext[FIELD_W-1:0];
        end
        dq_nxt      = seen_first_r ? ivl_nxt : '0;
        rem_nxt     = '0;
        bit_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        // shift in one dividend bit, shift out one quotient bit
        rem_nxt     = rem_ge ? rem_sh - {1'b0, divisor_r} : rem_sh;
        dq_nxt      = {dq_r[FIELD_W-2:0], rem_ge};
        bit_cnt_nxt = bit_cnt_r + 5'd1;
        if (bit_cnt_r == 5'(FIELD_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {drops, max_ivl, missed, ivl_r, swap_count_r};
          out_tuser_nxt  = {drop, seen_first_r};
          last_time_nxt  = now_r;
          seen_first_nxt = 1'b1;
          longest_nxt    = max_ivl;
          drop_events_nxt = drops;
          if (swap_count_r != ALL_ONES) begin
            swap_count_nxt = swap_count_r + FIELD_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      last_time_r   <= '0;
      seen_first_r  <= 1'b0;
      swap_count_r  <= '0;
      longest_r     <= '0;
      drop_events_r <= '0;
      period_r      <= PERIOD_DEFAULT;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      last_time_r   <= last_time_nxt;
      seen_first_r  <= seen_first_nxt;
      swap_count_r  <= swap_count_nxt;
      longest_r     <= longest_nxt;
      drop_events_r <= drop_events_nxt;
      period_r      <= period_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    divisor_r   <= divisor_nxt;
    ivl_r       <= ivl_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

endmodule

### design/fidm_checker.sv
// Port-level checks for frame_interval_drop_monitor, bound to the top level.
// Depends on fidm_pkg.
module fidm_checker
  import fidm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [FIELD_W-1:0]    in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [FIELD_W-1:0]    cfg_data
);

  logic [FIELD_W-1:0] missed;
  logic [FIELD_W-1:0] interval;
  logic [FIELD_W-1:0] max_interval;

  assign missed       = out_tdata[OFS_MISSED +: FIELD_W];
  assign interval     = out_tdata[OFS_INTERVAL +: FIELD_W];
  assign max_interval = out_tdata[OFS_MAX_INTERVAL +: FIELD_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed under stall");

  a_drop_missed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[USR_DROPPED] == (missed != '0))
    else $error("dropped flag disagrees with missed count");

  a_first_swap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[USR_HAS_INTERVAL] |-> interval == '0 && missed == '0)
    else $error("first swap carries an interval");

  a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> max_interval >= interval)
    else $error("max_interval below interval");

endmodule

bind frame_interval_drop_monitor fidm_checker u_fidm_checker (.*);

### tb/sv/frame_interval_drop_monitor_test.sv
// Testbench for frame_interval_drop_monitor: streams swap timestamps and checks
// every result beat against an in-bench predictor across several refresh periods.
// Depends on fidm_pkg and the frame_interval_drop_monitor RTL.
module frame_interval_drop_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fidm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef logic [FIELD_W-1:0] word_t;

  typedef struct packed {
    word_t frame_index;
    logic  has_interval;
    word_t interval;
    word_t missed;
    logic  dropped;
    word_t max_interval;
    word_t dropped_total;
  } swap_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  word_t                 in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  word_t                 cfg_data = '0;

  word_t        swap_q[$];
  swap_report_t report_q[$];
  swap_report_t got_report;

  word_t       period_reg = PERIOD_DEFAULT;
  word_t       prev_swap = '0;
  logic        have_prev = 1'b0;
  word_t       swap_count = '0;
  word_t       longest = '0;
  word_t       drop_count = '0;
  word_t       gen_last = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors = 0;
  int unsigned beats = 0;
  int unsigned cycle_count = 0;

  frame_interval_drop_monitor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic swap_report_t predict_swap(input word_t now);
    swap_report_t r;
    word_t        eff_period;
    word_t        quot;
    r = '0;
    r.frame_index = swap_count;
    if (have_prev) begin
      eff_period = (period_reg == '0) ? PERIOD_DEFAULT : period_reg;
      r.has_interval = 1'b1;
      r.interval = now - prev_swap;
      if (r.interval > longest) longest = r.interval;
      quot = r.interval / eff_period;
      if (quot >= 2) begin
        r.missed = quot - 1;
        r.dropped = 1'b1;
        if (drop_count != ALL_ONES) drop_count = drop_count + 1;
      end
    end
    r.max_interval = longest;
    r.dropped_total = drop_count;
    prev_swap = now;
    have_prev = 1'b1;
    if (swap_count != ALL_ONES) swap_count = swap_count + 1;
    return r;
  endfunction

  function automatic word_t next_swap(input word_t prev, input word_t period);
    longint unsigned eff;
    longint unsigned step;
    int unsigned     pick;
    int unsigned     k;
    eff = (period == '0) ? PERIOD_DEFAULT : period;
    pick = $urandom_range(99, 0);
    if (pick < 65) begin
      k = $urandom_range(4, 0);
      step = eff * k + $urandom_range(32'(eff >> 2), 0);
      if (k > 0) step = step - (eff >> 3);
      return prev + word_t'(step);
    end else if (pick < 75) begin
      return $urandom;
    end else if (pick < 85) begin
      return prev + $urandom_range(3, 0);
    end else if (pick < 93) begin
      return prev + ALL_ONES - $urandom_range(3, 0);
    end
    return prev + word_t'(eff * $urandom_range(64, 2));
  endfunction

  task automatic push_at(input word_t value);
    swap_q.push_back(value);
    gen_last = value;
  endtask

  task automatic add_random(input int unsigned count);
    repeat (count) push_at(next_swap(gen_last, period_reg));
  endtask

  task automatic wait_idle();
    while (swap_q.size() != 0 || in_tvalid || report_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_period(input word_t value);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    period_reg = value;
    cfg_valid <= 1'b0;
  endtask

  // driver: predict on each accepted beat, then present the next pending swap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        report_q.push_back(predict_swap(in_tdata));
      end
      if (!in_tvalid || in_tready) begin
        if (swap_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_tdata  <= swap_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        beats++;
        got_report.frame_index   = out_tdata[OFS_FRAME_INDEX +: FIELD_W];
        got_report.has_interval  = out_tuser[USR_HAS_INTERVAL];
        got_report.interval      = out_tdata[OFS_INTERVAL +: FIELD_W];
        got_report.missed        = out_tdata[OFS_MISSED +: FIELD_W];
        got_report.dropped       = out_tuser[USR_DROPPED];
        got_report.max_interval  = out_tdata[OFS_MAX_INTERVAL +: FIELD_W];
        got_report.dropped_total = out_tdata[OFS_DROPPED_TOTAL +: FIELD_W];
        if (report_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("unexpected result beat %0d: idx=%0d", beats, got_report.frame_index);
        end else if (got_report != report_q[0]) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display({"mismatch beat %0d\n",
                      "  expected idx=%0d has=%b ivl=%h miss=%h drop=%b max=%h total=%0d\n",
                      "  actual   idx=%0d has=%b ivl=%h miss=%h drop=%b max=%h total=%0d"},
                     beats,
                     report_q[0].frame_index, report_q[0].has_interval,
                     report_q[0].interval, report_q[0].missed, report_q[0].dropped,
                     report_q[0].max_interval, report_q[0].dropped_total,
                     got_report.frame_index, got_report.has_interval,
                     got_report.interval, got_report.missed, got_report.dropped,
                     got_report.max_interval, got_report.dropped_total);
          void'(report_q.pop_front());
        end else begin
          void'(report_q.pop_front());
        end
      end
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 57;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // default period: first swap, zero interval, just below and at a drop,
    // wrap of the timestamp and the largest interval
    push_at(32'd0);
    push_at(32'd0);
    push_at(32'd16667);
    push_at(32'd50000);
    push_at(32'd83334);
    push_at(32'd250004);
    push_at(32'hFFFF_FFFF);
    push_at(32'h0000_00FE);
    push_at(32'h0000_00FD);
    push_at(32'h0000_00FD + 32'd50001);
    add_random(250);

    // zero period acts as the default
    write_period('0);
    push_at(gen_last + 32'd33334);
    push_at(gen_last + 32'd33333);
    add_random(200);

    write_period(32'd1);
    push_at(gen_last + 32'd1);
    push_at(gen_last + 32'd2);
    push_at(gen_last);
    push_at(gen_last - 32'd1);
    add_random(200);

    send_idle_pct = 57;
    recv_idle_pct = 32;
    write_period(ALL_ONES);
    push_at(gen_last - 32'd1);
    push_at(gen_last);
    add_random(200);

    write_period($urandom_range(50000, 1000));
    add_random(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_period($urandom_range(64, 1));
    add_random(250);

    write_period(PERIOD_DEFAULT);
    add_random(300);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && report_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
